### rtl/core/lpht_pkg.sv
package lpht_pkg;

  // Table geometry. The slot count is a power of two.
  localparam int SLOTS = 1024;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = 11;
  localparam int KEY_W = 64;
  localparam int VAL_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

  localparam idx_t IDX_MAX   = IDX_W'(SLOTS - 1);
  localparam cnt_t SLOTS_CNT = CNT_W'(SLOTS);

  // Reserved key codes and the filler value.
  localparam key_t EMPTY_KEY = '0;
  localparam key_t TOMB_KEY  = 64'h0000_0000_FFFF_FFFF;
  localparam val_t NO_VALUE  = 32'hFFFF_FFFF;

  // Configuration port.
  localparam int   CFG_ADDR_W     = 3;
  localparam logic REG_MAX_FILL   = 1'b0;
  localparam cnt_t MAX_FILL_RESET = 11'd768;

  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_PROBE,
    S_REM_NEXT,
    S_REM_BACK,
    S_RESP
  } state_t;

  // One cycle's access to the slot store: one read address, one write address.
  typedef struct packed {
    idx_t raddr;
    idx_t waddr;
    logic key_we;
    key_t key_wdata;
    logic val_we;
    val_t val_wdata;
  } store_req_t;

endpackage

### rtl/core/lpht_if.sv
interface lpht_in_if import lpht_pkg::*;;
  logic  valid;
  logic  ready;
  func_t func;
  key_t  key;
  val_t  value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lpht_out_if import lpht_pkg::*;;
  logic    valid;
  logic    ready;
  val_t    read_value;
  status_t status;
  logic    over_threshold;
  cnt_t    probe_count;
  cnt_t    entries_used;
  cnt_t    tombstones_held;

  modport source (output valid, output read_value, output status, output over_threshold,
                  output probe_count, output entries_used, output tombstones_held,
                  input ready);
  modport sink   (input valid, input read_value, input status, input over_threshold,
                  input probe_count, input entries_used, input tombstones_held,
                  output ready);
endinterface

### rtl/core/linear_probe_hash_table.sv
// Open-addressing key/value table with linear probing over SLOTS (1024) slots held in a
// key memory and a value memory, each with a registered read port. Every beat on the
// input channel (get, set, remove or clear) yields exactly one result beat. The probe
// loop reads one slot per cycle until it finds the key, an empty slot or a full lap; a
// remove then inspects the following slot and, when that slot is empty, walks backward
// and empties each tombstone it reclaims. A rejected key goes to its result unprobed.
// A clear sweeps the key memory one slot per cycle. A finished item waits in its result
// state for as long as the previous result still blocks the output register. After reset
// the same sweep empties every slot before the first beat is accepted; the max_fill
// register can be written meanwhile. One item is in flight at a time, but a new item is
// accepted while the previous result still waits in the output register.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lpht_in_if.sink               in_ch,
  lpht_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cnt_t       max_fill;
  store_req_t req;
  key_t       key_rdata;
  val_t       val_rdata;

  lpht_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .max_fill (max_fill)
  );

  lpht_store u_store (
    .clk       (clk),
    .req       (req),
    .key_rdata (key_rdata),
    .val_rdata (val_rdata)
  );

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_fill  (max_fill),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .req       (req),
    .key_rdata (key_rdata),
    .val_rdata (val_rdata)
  );

  // An accepted beat always makes the block busy and drops input ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accepted beat");

  // A rejected key never probes.
  a_invalid_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_INVALID) |-> (out_ch.probe_count == '0))
    else $error("invalid key reported probe steps");

  // Only a successful lookup carries a stored value.
  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.read_value == NO_VALUE))
    else $error("failed operation returned a value");

  // Live entries and tombstones never exceed the slot count.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      (({1'b0, out_ch.entries_used} + {1'b0, out_ch.tombstones_held}) <= {1'b0, SLOTS_CNT}))
    else $error("fill counts exceed the table size");

endmodule

### rtl/core/lpht_store.sv
module lpht_store import lpht_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output key_t       key_rdata,
  output val_t       val_rdata
);

  key_t keys_mem [SLOTS];
  val_t vals_mem [SLOTS];
  key_t key_rd_r;
  val_t val_rd_r;

  // Key array: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (req.key_we) begin
      keys_mem[req.waddr] <= req.key_wdata;
    end
    key_rd_r <= keys_mem[req.raddr];
  end

  // Value array shares the addresses of the key array.
  always_ff @(posedge clk) begin
    if (req.val_we) begin
      vals_mem[req.waddr] <= req.val_wdata;
    end
    val_rd_r <= vals_mem[req.raddr];
  end

  assign key_rdata = key_rd_r;
  assign val_rdata = val_rd_r;

endmodule

### rtl/core/lpht_cfg.sv
module lpht_cfg import lpht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cnt_t                  max_fill
);

  cnt_t max_fill_r;
  logic reg_idx;

  assign reg_idx = paddr[CFG_ADDR_W-1];
  assign pready  = 1'b1;

  // Register write on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fill_r <= MAX_FILL_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_MAX_FILL)) begin
      max_fill_r <= pwdata[CNT_W-1:0];
    end
  end

  // Read back; addresses with the top address bit set read as zero.
  always_comb begin
    if (reg_idx == REG_MAX_FILL) begin
      prdata = 32'(max_fill_r);
    end else begin
      prdata = '0;
    end
  end

  assign max_fill = max_fill_r;

endmodule

### rtl/core/lpht_ctrl.sv
module lpht_ctrl import lpht_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cnt_t       max_fill,
  lpht_in_if.sink    in_ch,
  lpht_out_if.source out_ch,
  output store_req_t req,
  input  key_t       key_rdata,
  input  val_t       val_rdata
);

  state_t  state_r, state_nxt;
  idx_t    idx_r, idx_nxt;
  cnt_t    n_r, n_nxt;
  cnt_t    k_r, k_nxt;
  cnt_t    live_r, live_nxt;
  cnt_t    tomb_r, tomb_nxt;
  logic    emit_r, emit_nxt;
  func_t   op_r, op_nxt;
  key_t    key_r, key_nxt;
  val_t    val_r, val_nxt;
  val_t    rv_r, rv_nxt;
  status_t status_r, status_nxt;

  logic    out_valid_r, out_valid_nxt;
  val_t    out_rv_r, out_rv_nxt;
  status_t out_status_r, out_status_nxt;
  logic    out_over_r, out_over_nxt;
  cnt_t    out_probe_r, out_probe_nxt;
  cnt_t    out_live_r, out_live_nxt;
  cnt_t    out_tomb_r, out_tomb_nxt;

  logic accept;
  logic in_key_ok;
  logic hit;
  logic empty;
  logic stop;
  logic out_free;
  logic back_more;
  logic [CNT_W:0] fill_sum;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_key_ok = (in_ch.key != EMPTY_KEY) && (in_ch.key != TOMB_KEY);
  assign hit       = (key_rdata == key_r);
  assign empty     = (key_rdata == EMPTY_KEY);
  assign stop      = hit || empty || (n_r == SLOTS_CNT);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign back_more = (k_r != SLOTS_CNT) && (key_rdata == TOMB_KEY);
  assign fill_sum  = {1'b0, live_r} + {1'b0, tomb_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (idx_r == IDX_MAX) begin
          state_nxt = emit_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          priority if (in_ch.func == FUNC_CLEAR) begin
            state_nxt = S_SWEEP;
          end else if (!in_key_ok) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (stop) begin
          state_nxt = (op_r == FUNC_REMOVE && hit) ? S_REM_NEXT : S_RESP;
        end
      end
      S_REM_NEXT: begin
        state_nxt = (key_rdata != EMPTY_KEY) ? S_RESP : S_REM_BACK;
      end
      S_REM_BACK: begin
        if (!back_more) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, store accesses and handshake outputs.
  always_comb begin
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    live_nxt   = live_r;
    tomb_nxt   = tomb_r;
    emit_nxt   = emit_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    rv_nxt     = rv_r;
    status_nxt = status_r;

    // The probe reads one slot ahead; the read issued at a stop fetches the follower.
    req           = '0;
    req.raddr     = idx_r + idx_t'(1);
    req.waddr     = idx_r;
    req.key_wdata = key_r;
    req.val_wdata = val_r;

    in_ch.ready = (state_r == S_IDLE);

    out_valid_nxt  = out_valid_r;
    out_rv_nxt     = out_rv_r;
    out_status_nxt = out_status_r;
    out_over_nxt   = out_over_r;
    out_probe_nxt  = out_probe_r;
    out_live_nxt   = out_live_r;
    out_tomb_nxt   = out_tomb_r;

    unique case (state_r)
      S_SWEEP: begin
        req.key_we    = 1'b1;
        req.key_wdata = EMPTY_KEY;
        idx_nxt       = idx_r + idx_t'(1);
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_ch.func;
          key_nxt    = in_ch.key;
          val_nxt    = in_ch.value;
          n_nxt      = '0;
          rv_nxt     = NO_VALUE;
          status_nxt = ST_OK;
          idx_nxt    = in_ch.key[IDX_W-1:0];
          req.raddr  = in_ch.key[IDX_W-1:0];
          priority if (in_ch.func == FUNC_CLEAR) begin
            idx_nxt  = '0;
            emit_nxt = 1'b1;
            live_nxt = '0;
            tomb_nxt = '0;
          end else if (!in_key_ok) begin
            status_nxt = ST_INVALID;
          end
        end
      end
      S_PROBE: begin
        if (!stop) begin
          idx_nxt = idx_r + idx_t'(1);
          n_nxt   = n_r + cnt_t'(1);
        end else begin
          unique case (op_r)
            FUNC_GET: begin
              if (hit) begin
                rv_nxt = val_rdata;
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            FUNC_SET: begin
              priority if (hit) begin
                req.val_we = 1'b1;
              end else if (empty) begin
                req.key_we = 1'b1;
                req.val_we = 1'b1;
                live_nxt   = live_r + cnt_t'(1);
              end else begin
                status_nxt = ST_FULL;
              end
            end
            FUNC_REMOVE: begin
              if (!hit) begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      S_REM_NEXT: begin
        // The follower's key decides between tombstone and empty slot.
        req.key_we = 1'b1;
        if (live_r != '0) begin
          live_nxt = live_r - cnt_t'(1);
        end
        if (key_rdata != EMPTY_KEY) begin
          req.key_wdata = TOMB_KEY;
          tomb_nxt      = tomb_r + cnt_t'(1);
        end else begin
          req.key_wdata = EMPTY_KEY;
          idx_nxt       = idx_r - idx_t'(1);
          k_nxt         = '0;
          req.raddr     = idx_r - idx_t'(1);
        end
      end
      S_REM_BACK: begin
        // Walk backward, emptying the run of tombstones.
        req.raddr = idx_r - idx_t'(1);
        if (back_more) begin
          req.key_we    = 1'b1;
          req.key_wdata = EMPTY_KEY;
          idx_nxt       = idx_r - idx_t'(1);
          k_nxt         = k_r + cnt_t'(1);
          if (tomb_r != '0) begin
            tomb_nxt = tomb_r - cnt_t'(1);
          end
        end
      end
      S_RESP: begin
        emit_nxt = 1'b0;
      end
      default: ;
    endcase

    // Output register: loads the finished result as soon as it is free.
    if (state_r == S_RESP && out_free) begin
      out_valid_nxt  = 1'b1;
      out_rv_nxt     = rv_r;
      out_status_nxt = status_r;
      out_over_nxt   = (fill_sum > {1'b0, max_fill});
      out_probe_nxt  = n_r;
      out_live_nxt   = live_r;
      out_tomb_nxt   = tomb_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state; a reset starts a sweep that empties every slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      idx_r       <= '0;
      emit_r      <= 1'b0;
      live_r      <= '0;
      tomb_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      emit_r      <= emit_nxt;
      live_r      <= live_nxt;
      tomb_r      <= tomb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    rv_r         <= rv_nxt;
    status_r     <= status_nxt;
    out_rv_r     <= out_rv_nxt;
    out_status_r <= out_status_nxt;
    out_over_r   <= out_over_nxt;
    out_probe_r  <= out_probe_nxt;
    out_live_r   <= out_live_nxt;
    out_tomb_r   <= out_tomb_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_value      = out_rv_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.over_threshold  = out_over_r;
  assign out_ch.probe_count     = out_probe_r;
  assign out_ch.entries_used    = out_live_r;
  assign out_ch.tombstones_held = out_tomb_r;

endmodule

### tb/linear_probe_hash_table_tb.sv
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;
  localparam int REG_SPARE      = 1;
  localparam int HOLD_AT_BEAT   = 600;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [CFG_ADDR_W-1:0] MAX_FILL_ADDR = CFG_ADDR_W'(4 * REG_MAX_FILL);
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR    = CFG_ADDR_W'(4 * REG_SPARE);

  typedef struct packed {
    func_t func;
    key_t  key;
    val_t  value;
  } table_cmd_t;

  typedef struct packed {
    val_t    read_value;
    status_t status;
    logic    over_threshold;
    cnt_t    probe_count;
    cnt_t    entries_used;
    cnt_t    tombstones_held;
  } table_reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  lpht_in_if  in_if ();
  lpht_out_if out_if ();

  linear_probe_hash_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the slot store, the fill counters and the threshold register.
  key_t        slot_key [SLOTS];
  val_t        slot_val [SLOTS];
  int unsigned live_cnt;
  int unsigned tomb_cnt;
  cnt_t        fill_limit;

  table_cmd_t   cmd_queue [$];
  table_reply_t reply_queue [$];
  table_cmd_t   next_cmd;
  table_reply_t seen_reply;
  table_reply_t due_reply;

  int unsigned fail_cnt;
  int unsigned replies_seen;
  int unsigned stuck_cycles;
  int unsigned func_seen [4];
  int unsigned full_seen;
  int unsigned invalid_seen;
  int unsigned miss_seen;
  int unsigned flag_seen;
  int unsigned peak_probe;
  int unsigned tx_gap;
  int unsigned tx_calm;
  int unsigned rx_stall;
  int unsigned rx_calm;
  int unsigned hold_left;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void wipe_slots();
    for (int s = 0; s < SLOTS; s++) begin
      slot_key[s] = EMPTY_KEY;
    end
    live_cnt = 0;
    tomb_cnt = 0;
  endfunction

  // Apply one operation to the shadow table and return the reply it should produce.
  function automatic table_reply_t predict_reply(input func_t f, input key_t k, input val_t v);
    table_reply_t r;
    int unsigned  i;
    int unsigned  n;
    int unsigned  nx;
    int unsigned  j;
    int unsigned  m;
    r.read_value  = NO_VALUE;
    r.status      = ST_OK;
    r.probe_count = '0;
    if (f == FUNC_CLEAR) begin
      wipe_slots();
    end else if (k == EMPTY_KEY || k == TOMB_KEY) begin
      r.status = ST_INVALID;
    end else begin
      // Walk from the home slot until the key, an empty slot, or a full lap.
      i = 32'(k[IDX_W-1:0]);
      n = 0;
      while (slot_key[i] != k && slot_key[i] != EMPTY_KEY && n < SLOTS) begin
        i = (i + 1) % SLOTS;
        n++;
      end
      r.probe_count = cnt_t'(n);
      case (f)
        FUNC_GET: begin
          if (slot_key[i] == k) r.read_value = slot_val[i];
          else r.status = ST_NOT_FOUND;
        end
        FUNC_SET: begin
          if (slot_key[i] == k) begin
            slot_val[i] = v;
          end else if (slot_key[i] == EMPTY_KEY) begin
            slot_key[i] = k;
            slot_val[i] = v;
            live_cnt++;
          end else begin
            r.status = ST_FULL;
          end
        end
        default: begin
          if (slot_key[i] != k) begin
            r.status = ST_NOT_FOUND;
          end else begin
            nx = (i + 1) % SLOTS;
            if (slot_key[nx] != EMPTY_KEY) begin
              slot_key[i] = TOMB_KEY;
              tomb_cnt++;
            end else begin
              // Slot becomes empty; tombstones directly behind it go too, with wrap.
              slot_key[i] = EMPTY_KEY;
              j = (i + SLOTS - 1) % SLOTS;
              for (m = 0; m < SLOTS && slot_key[j] == TOMB_KEY; m++) begin
                slot_key[j] = EMPTY_KEY;
                if (tomb_cnt > 0) tomb_cnt--;
                j = (j + SLOTS - 1) % SLOTS;
              end
            end
            if (live_cnt > 0) live_cnt--;
          end
        end
      endcase
    end
    r.over_threshold  = (live_cnt + tomb_cnt > fill_limit);
    r.entries_used    = cnt_t'(live_cnt);
    r.tombstones_held = cnt_t'(tomb_cnt);
    return r;
  endfunction

  function automatic void enqueue(input func_t f, input key_t k, input val_t v);
    table_cmd_t c;
    c.func  = f;
    c.key   = k;
    c.value = v;
    cmd_queue.push_back(c);
  endfunction

  // Command driver: one beat in flight, with random gaps and calm stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        reply_queue.push_back(predict_reply(in_if.func, in_if.key, in_if.value));
        func_seen[in_if.func]++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          next_cmd = cmd_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.func  <= next_cmd.func;
          in_if.key   <= next_cmd.key;
          in_if.value <= next_cmd.value;
          if (tx_calm > 0) tx_calm--;
          else if ($urandom_range(0, 149) == 0) tx_calm = $urandom_range(40, 160);
          else tx_gap = pick_pause();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks every beat against the oldest prediction and drives ready.
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      seen_reply.read_value      = out_if.read_value;
      seen_reply.status          = out_if.status;
      seen_reply.over_threshold  = out_if.over_threshold;
      seen_reply.probe_count     = out_if.probe_count;
      seen_reply.entries_used    = out_if.entries_used;
      seen_reply.tombstones_held = out_if.tombstones_held;
      replies_seen++;
      if (reply_queue.size() == 0) begin
        report_fail($sformatf("result beat %0d arrived with nothing pending: value %h status %0d",
                              replies_seen, seen_reply.read_value, seen_reply.status));
      end else begin
        due_reply = reply_queue.pop_front();
        if (seen_reply.read_value !== due_reply.read_value ||
            seen_reply.status !== due_reply.status ||
            seen_reply.over_threshold !== due_reply.over_threshold ||
            seen_reply.probe_count !== due_reply.probe_count ||
            seen_reply.entries_used !== due_reply.entries_used ||
            seen_reply.tombstones_held !== due_reply.tombstones_held) begin
          report_fail($sformatf({"result beat %0d mismatch: expected value %h status %0d ",
                                 "flag %0b probes %0d live %0d tomb %0d, got value %h ",
                                 "status %0d flag %0b probes %0d live %0d tomb %0d"},
                                replies_seen, due_reply.read_value, due_reply.status,
                                due_reply.over_threshold, due_reply.probe_count,
                                due_reply.entries_used, due_reply.tombstones_held,
                                seen_reply.read_value, seen_reply.status,
                                seen_reply.over_threshold, seen_reply.probe_count,
                                seen_reply.entries_used, seen_reply.tombstones_held));
        end
        if (due_reply.status == ST_FULL) full_seen++;
        if (due_reply.status == ST_INVALID) invalid_seen++;
        if (due_reply.status == ST_NOT_FOUND) miss_seen++;
        if (due_reply.over_threshold) flag_seen++;
        if (due_reply.probe_count > peak_probe) peak_probe = 32'(due_reply.probe_count);
      end
    end

    // One long hold-off lets the block back up and stall its input.
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && replies_seen >= HOLD_AT_BEAT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 149) == 0) rx_calm = $urandom_range(40, 160);
      else rx_stall = pick_pause();
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", stuck_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MAX_FILL_ADDR) fill_limit = cnt_t'(data);
  endtask

  task automatic cfg_check(input logic [CFG_ADDR_W-1:0] addr);
    logic [31:0] want;
    want = 32'(fill_limit);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      report_fail($sformatf("max_fill readback: expected %0d, got %0d", want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_fill_limit(input int unsigned limit);
    cfg_write(MAX_FILL_ADDR, 32'(limit));
    cfg_check(MAX_FILL_ADDR);
    @(negedge clk);
  endtask

  // Block until every queued command has been sent and every reply has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_if.valid || reply_queue.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Random traffic over a small pool of keys whose home slots crowd into one window.
  task automatic churn(input int unsigned n_items, input int unsigned pool_n,
                       input int unsigned base, input int unsigned span);
    key_t        pool [$];
    key_t        k;
    int unsigned r;
    repeat (pool_n) begin
      k = {$urandom, $urandom};
      k[IDX_W-1:0] = idx_t'((base + $urandom_range(0, span - 1)) % SLOTS);
      if (k == EMPTY_KEY || k == TOMB_KEY) k[40] = 1'b1;
      pool.push_back(k);
    end
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      k = pool[$urandom_range(0, pool_n - 1)];
      if (r < 38) enqueue(FUNC_SET, k, $urandom);
      else if (r < 66) enqueue(FUNC_GET, k, $urandom);
      else if (r < 92) enqueue(FUNC_REMOVE, k, $urandom);
      else if (r < 94) enqueue(FUNC_CLEAR, {$urandom, $urandom}, $urandom);
      else if (r < 96) enqueue(func_t'($urandom_range(0, 2)),
                               $urandom_range(0, 1) ? EMPTY_KEY : TOMB_KEY, $urandom);
      else enqueue(func_t'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom);
    end
  endtask

  // Fill every slot with distinct keys, then poke the completely full table.
  task automatic fill_to_capacity();
    key_t        added [$];
    bit          taken [key_t];
    key_t        k;
    int unsigned pick;
    enqueue(FUNC_CLEAR, {$urandom, $urandom}, $urandom);
    while (added.size() < SLOTS) begin
      if (added.size() > 0 && $urandom_range(0, 99) < 1) begin
        pick = $urandom_range(0, added.size() - 1);
        enqueue($urandom_range(0, 1) ? FUNC_GET : FUNC_SET, added[pick], $urandom);
      end else begin
        do k = {$urandom, $urandom};
        while (k == EMPTY_KEY || k == TOMB_KEY || taken.exists(k));
        taken[k] = 1'b1;
        added.push_back(k);
        enqueue(FUNC_SET, k, $urandom);
      end
    end
    do k = {$urandom, $urandom};
    while (k == EMPTY_KEY || k == TOMB_KEY || taken.exists(k));
    enqueue(FUNC_SET, k, $urandom);
    enqueue(FUNC_GET, k, $urandom);
    enqueue(FUNC_REMOVE, k, $urandom);
    repeat (3) enqueue(FUNC_GET, added[$urandom_range(0, SLOTS - 1)], $urandom);
    // With no empty slot left, a removed key leaves a tombstone that is never reused.
    enqueue(FUNC_REMOVE, added[0], $urandom);
    enqueue(FUNC_GET, added[1], $urandom);
    enqueue(FUNC_SET, added[0], $urandom);
    enqueue(FUNC_CLEAR, {$urandom, $urandom}, $urandom);
  endtask

  initial begin
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.func   = FUNC_GET;
    in_if.key    = EMPTY_KEY;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    fill_limit   = MAX_FILL_RESET;
    wipe_slots();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset value first, then a low threshold for the directed beats.
    cfg_check(MAX_FILL_ADDR);
    set_fill_limit(2);
    cfg_write(SPARE_ADDR, 32'h0000_07FF);
    cfg_check(MAX_FILL_ADDR);
    @(negedge clk);

    // Directed: collisions, overwrite, reserved keys, wrap at the top slot,
    // tombstone creation and the backward sweep that reclaims tombstones.
    enqueue(FUNC_GET,    64'h5, 32'h1234_5678);
    enqueue(FUNC_SET,    64'h5, 32'h0000_0000);
    enqueue(FUNC_SET,    64'h5, 32'hFFFF_FFFF);
    enqueue(FUNC_GET,    64'h5, 32'h0);
    enqueue(FUNC_SET,    64'h405, 32'h5A5A_5A5A);
    enqueue(FUNC_SET,    64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5);
    enqueue(FUNC_SET,    64'h1_FFFF_FFFF, 32'hC3C3_3C3C);
    enqueue(FUNC_GET,    64'h1_FFFF_FFFF, 32'h0);
    enqueue(FUNC_GET,    TOMB_KEY, 32'h0);
    enqueue(FUNC_SET,    EMPTY_KEY, 32'hDEAD_BEEF);
    enqueue(FUNC_REMOVE, TOMB_KEY, 32'h0);
    enqueue(FUNC_GET,    EMPTY_KEY, 32'h0);
    enqueue(FUNC_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    enqueue(FUNC_GET,    64'h1_FFFF_FFFF, 32'h0);
    enqueue(FUNC_REMOVE, 64'h1_FFFF_FFFF, 32'h0);
    enqueue(FUNC_REMOVE, 64'h805, 32'h0);
    enqueue(FUNC_REMOVE, 64'h5, 32'h0);
    enqueue(FUNC_REMOVE, 64'h405, 32'h0);
    enqueue(FUNC_SET,    64'h8000_0000_0000_0003, 32'h8000_0001);
    enqueue(FUNC_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    enqueue(FUNC_GET,    64'h8000_0000_0000_0003, 32'h0);
    wait_idle();

    // Dense cluster that wraps past the last slot; flag raised by any entry.
    set_fill_limit(0);
    churn(30, 12, SLOTS - 8, 16);
    wait_idle();

    // Wider spread at the top threshold, which can never be exceeded.
    set_fill_limit(SLOTS);
    churn(20, 16, $urandom_range(0, SLOTS - 1), 64);
    wait_idle();

    // Fill to the brim; the flag rises once the fill passes the threshold.
    set_fill_limit(1000);
    fill_to_capacity();
    wait_idle();

    repeat (20) @(negedge clk);
    fail_cnt += reply_queue.size();
    $display("Ran %0d gets, %0d sets, %0d removes and %0d clears over four threshold settings.",
             func_seen[FUNC_GET], func_seen[FUNC_SET], func_seen[FUNC_REMOVE],
             func_seen[FUNC_CLEAR]);
    $display("Saw %0d misses, %0d full-table, %0d invalid-key, %0d flagged; longest probe %0d.",
             miss_seen, full_seen, invalid_seen, flag_seen, peak_probe);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
